// ----- rtl/cau_pkg.sv -----
// shared types, constants and arithmetic helpers of the complex arithmetic unit
`default_nettype none
package cau_pkg;

	// word format
	localparam int W     = 32;
	localparam int F     = 16;
	localparam int PW    = 2 * W;
	localparam int VW    = 2 * W + 1;
	localparam int RW    = W + 3;
	localparam int ZW    = PW + W - F;
	localparam int NSTEP = W;

	// command codes
	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;
	localparam logic [2:0] CMD_MAG = 3'd4;
	localparam logic [2:0] CMD_CMP = 3'd5;

	typedef logic signed [W-1:0]  word_t;
	typedef logic signed [W:0]    wsum_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [VW-1:0] wide_t;

	typedef struct packed {
		logic [W-1:0] val;
		logic         flag;
	} sat_t;

	typedef struct packed {
		logic [PW-1:0] rem;
		logic          q;
	} dstep_t;

	// payload of one divide / square root stage
	typedef struct packed {
		logic [2:0]    cmd;
		logic [W-1:0]  fre;
		logic [W-1:0]  fim;
		logic          fsat;
		logic          feq;
		logic          dz;
		logic [PW-1:0] den;
		logic [PW-1:0] rre;
		logic [PW-1:0] rim;
		logic [W-1:0]  qre;
		logic [W-1:0]  qim;
		logic [W-1:0]  lore;
		logic [W-1:0]  loim;
		logic          nre;
		logic          nim;
		logic          ore;
		logic          oim;
		logic [RW-1:0] srem;
		logic [W-1:0]  root;
		logic [PW-1:0] rad;
	} step_t;

	// clamp a sign and magnitude to the word range
	function automatic sat_t saturate(input logic neg, input logic [VW-1:0] mag);
		sat_t r;
		logic [VW-1:0] lim;
		lim    = VW'(1) << (W - 1);
		r.flag = 1'b0;
		r.val  = W'(mag);
		if (!neg) begin
			if (mag >= lim) begin
				r.flag = 1'b1;
				r.val  = {1'b0, {(W-1){1'b1}}};
			end
		end else begin
			if (mag > lim) begin
				r.flag = 1'b1;
				r.val  = {1'b1, {(W-1){1'b0}}};
			end else begin
				r.val = W'(VW'(0) - mag);
			end
		end
		return r;
	endfunction

	// clamp a signed wide value
	function automatic sat_t sat_signed(input wide_t v);
		logic [VW-1:0] mag;
		mag = v[VW-1] ? $unsigned(-v) : $unsigned(v);
		return saturate(v[VW-1], mag);
	endfunction

	// one restoring division step
	function automatic dstep_t div_step(input logic [PW-1:0] rem, input logic [PW-1:0] den,
			input logic nb);
		dstep_t r;
		logic [PW:0] t;
		t = {rem, nb};
		if (t >= {1'b0, den}) begin
			r.rem = PW'(t - {1'b0, den});
			r.q   = 1'b1;
		end else begin
			r.rem = t[PW-1:0];
			r.q   = 1'b0;
		end
		return r;
	endfunction

	// one quotient bit for both divide lanes and one root bit
	function automatic step_t pipe_step(input step_t s);
		step_t r;
		dstep_t a;
		dstep_t b;
		logic [RW-1:0] tr;
		logic [RW-1:0] t;
		r      = s;
		a      = div_step(s.rre, s.den, s.lore[W-1]);
		b      = div_step(s.rim, s.den, s.loim[W-1]);
		r.rre  = a.rem;
		r.rim  = b.rem;
		r.qre  = {s.qre[W-2:0], a.q};
		r.qim  = {s.qim[W-2:0], b.q};
		r.lore = s.lore << 1;
		r.loim = s.loim << 1;
		tr     = {s.srem[RW-3:0], s.rad[PW-1:PW-2]};
		t      = RW'({s.root, 2'b01});
		if (tr >= t) begin
			r.srem = tr - t;
			r.root = {s.root[W-2:0], 1'b1};
		end else begin
			r.srem = tr;
			r.root = {s.root[W-2:0], 1'b0};
		end
		r.rad = s.rad << 2;
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/cau_in_if.sv -----
// operand channel of the complex arithmetic unit
`default_nettype none
interface cau_in_if import cau_pkg::*; ();
	logic         valid;
	logic         ready;
	logic [2:0]   cmd;
	word_t        a_re;
	word_t        a_im;
	word_t        b_re;
	word_t        b_im;

	modport source(output valid, cmd, a_re, a_im, b_re, b_im, input ready);
	modport sink(input valid, cmd, a_re, a_im, b_re, b_im, output ready);
endinterface
`default_nettype wire

// ----- rtl/cau_out_if.sv -----
// result channel of the complex arithmetic unit
`default_nettype none
interface cau_out_if import cau_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t res_re;
	word_t res_im;
	logic  equal;
	logic  div_zero;
	logic  saturated;

	modport source(output valid, res_re, res_im, equal, div_zero, saturated, input ready);
	modport sink(input valid, res_re, res_im, equal, div_zero, saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/complex_arith_unit.sv -----
// complex arithmetic unit: Q16.16 add, sub, mul, div, magnitude and compare
// path: stage 1, stage 2, stage 3, the 32 divide and root stages, then the output register
// throughput: one transaction per cycle while results are taken; set by the 32 bit-per-stage divide and root stages
// the whole pipeline holds while a result waits at the output and is not taken
// reset clears the valid bits only; data registers are not reset
`default_nettype none
module complex_arith_unit import cau_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cau_in_if.sink     req,
	cau_out_if.source  rsp
);

	logic en;

	logic       v_s1;
	logic [2:0] cmd_s1;
	prod_t      m_s1 [6];
	wsum_t      sre_s1;
	wsum_t      sim_s1;
	logic       eq_s1;

	logic          v_s2;
	logic [2:0]    cmd_s2;
	wide_t         vre_s2;
	wide_t         vim_s2;
	logic [PW-1:0] den_s2;
	logic [W-1:0]  fre_s2;
	logic [W-1:0]  fim_s2;
	logic          fsat_s2;
	logic          feq_s2;

	step_t          stg_s [NSTEP+1];
	logic [NSTEP:0] vld_s;

	logic         valid_q;
	logic [W-1:0] re_q;
	logic [W-1:0] im_q;
	logic         eq_q;
	logic         dz_q;
	logic         sat_q;

	// global advance when the output register is free or being taken
	assign en        = !valid_q || rsp.ready;
	assign req.ready = en;

	// stage 1: products, plain sums and the equality test
	word_t xre_c;
	word_t xim_c;
	wsum_t sre_c;
	wsum_t sim_c;
	assign xre_c = (req.cmd == CMD_MAG) ? req.a_re : req.b_re;
	assign xim_c = (req.cmd == CMD_MAG) ? req.a_im : req.b_im;

	always_comb begin
		if (req.cmd == CMD_SUB) begin
			sre_c = wsum_t'(req.a_re) - wsum_t'(req.b_re);
			sim_c = wsum_t'(req.a_im) - wsum_t'(req.b_im);
		end else begin
			sre_c = wsum_t'(req.a_re) + wsum_t'(req.b_re);
			sim_c = wsum_t'(req.a_im) + wsum_t'(req.b_im);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= req.cmd;
			m_s1[0] <= prod_t'(req.a_re) * prod_t'(req.b_re);
			m_s1[1] <= prod_t'(req.a_im) * prod_t'(req.b_im);
			m_s1[2] <= prod_t'(req.a_re) * prod_t'(req.b_im);
			m_s1[3] <= prod_t'(req.a_im) * prod_t'(req.b_re);
			m_s1[4] <= prod_t'(xre_c) * prod_t'(xre_c);
			m_s1[5] <= prod_t'(xim_c) * prod_t'(xim_c);
			sre_s1  <= sre_c;
			sim_s1  <= sim_c;
			eq_s1   <= (req.a_re == req.b_re) && (req.a_im == req.b_im);
		end
	end

	// stage 2: product sums, denominator or radicand, add/sub/compare results
	wide_t         vre_c;
	wide_t         vim_c;
	logic [PW-1:0] den_c;
	sat_t          are_c;
	sat_t          aim_c;
	logic [W-1:0]  fre_c;
	logic [W-1:0]  fim_c;
	logic          fsat_c;
	logic          feq_c;

	assign den_c = $unsigned(m_s1[4]) + $unsigned(m_s1[5]);
	assign are_c = sat_signed(wide_t'(sre_s1));
	assign aim_c = sat_signed(wide_t'(sim_s1));

	always_comb begin
		vre_c  = '0;
		vim_c  = '0;
		fre_c  = '0;
		fim_c  = '0;
		fsat_c = 1'b0;
		feq_c  = 1'b0;
		case (cmd_s1)
			CMD_ADD, CMD_SUB: begin
				fre_c  = are_c.val;
				fim_c  = aim_c.val;
				fsat_c = are_c.flag | aim_c.flag;
			end
			CMD_MUL: begin
				vre_c = wide_t'(m_s1[0]) - wide_t'(m_s1[1]);
				vim_c = wide_t'(m_s1[2]) + wide_t'(m_s1[3]);
			end
			CMD_DIV: begin
				vre_c = wide_t'(m_s1[0]) + wide_t'(m_s1[1]);
				vim_c = wide_t'(m_s1[3]) - wide_t'(m_s1[2]);
			end
			CMD_CMP: begin
				feq_c = eq_s1;
			end
			default: begin
				fre_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2  <= cmd_s1;
			vre_s2  <= vre_c;
			vim_s2  <= vim_c;
			den_s2  <= den_c;
			fre_s2  <= fre_c;
			fim_s2  <= fim_c;
			fsat_s2 <= fsat_c;
			feq_s2  <= feq_c;
		end
	end

	// stage 3: multiply truncation and clamp, divide setup and overflow check, root setup
	logic [VW-1:0] amre_c;
	logic [VW-1:0] amim_c;
	sat_t          mre_c;
	sat_t          mim_c;
	step_t         p0_c;

	assign amre_c = vre_s2[VW-1] ? $unsigned(-vre_s2) : $unsigned(vre_s2);
	assign amim_c = vim_s2[VW-1] ? $unsigned(-vim_s2) : $unsigned(vim_s2);
	assign mre_c  = saturate(vre_s2[VW-1], amre_c >> F);
	assign mim_c  = saturate(vim_s2[VW-1], amim_c >> F);

	always_comb begin
		p0_c      = '0;
		p0_c.cmd  = cmd_s2;
		p0_c.fre  = fre_s2;
		p0_c.fim  = fim_s2;
		p0_c.fsat = fsat_s2;
		p0_c.feq  = feq_s2;
		if (cmd_s2 == CMD_MUL) begin
			p0_c.fre  = mre_c.val;
			p0_c.fim  = mim_c.val;
			p0_c.fsat = mre_c.flag | mim_c.flag;
		end
		p0_c.dz   = (cmd_s2 == CMD_DIV) && (den_s2 == '0);
		p0_c.den  = den_s2;
		p0_c.rre  = PW'(amre_c >> (W - F));
		p0_c.rim  = PW'(amim_c >> (W - F));
		p0_c.lore = W'(amre_c << F);
		p0_c.loim = W'(amim_c << F);
		p0_c.nre  = vre_s2[VW-1];
		p0_c.nim  = vim_s2[VW-1];
		p0_c.ore  = ZW'(amre_c) >= {den_s2, {(W-F){1'b0}}};
		p0_c.oim  = ZW'(amim_c) >= {den_s2, {(W-F){1'b0}}};
		p0_c.rad  = den_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_s[0] <= p0_c;
		end
	end

	// divide and root stages, one quotient and one root bit each
	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[k+1] <= pipe_step(stg_s[k]);
			end
		end
	end

	// result select and clamp
	step_t        last_c;
	sat_t         dre_c;
	sat_t         dim_c;
	sat_t         rt_c;
	logic [W-1:0] ore_c;
	logic [W-1:0] oim_c;
	logic         oeq_c;
	logic         odz_c;
	logic         osat_c;

	assign last_c = stg_s[NSTEP];
	assign dre_c  = saturate(last_c.nre, VW'({last_c.ore, last_c.qre}));
	assign dim_c  = saturate(last_c.nim, VW'({last_c.oim, last_c.qim}));
	assign rt_c   = saturate(1'b0, VW'(last_c.root));

	always_comb begin
		ore_c  = last_c.fre;
		oim_c  = last_c.fim;
		oeq_c  = last_c.feq;
		odz_c  = 1'b0;
		osat_c = last_c.fsat;
		case (last_c.cmd)
			CMD_DIV: begin
				if (last_c.dz) begin
					ore_c  = '0;
					oim_c  = '0;
					odz_c  = 1'b1;
					osat_c = 1'b0;
				end else begin
					ore_c  = dre_c.val;
					oim_c  = dim_c.val;
					osat_c = dre_c.flag | dim_c.flag;
				end
			end
			CMD_MAG: begin
				ore_c  = rt_c.val;
				oim_c  = '0;
				osat_c = rt_c.flag;
			end
			default: begin
				ore_c = last_c.fre;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= vld_s[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_q  <= ore_c;
			im_q  <= oim_c;
			eq_q  <= oeq_c;
			dz_q  <= odz_c;
			sat_q <= osat_c;
		end
	end

	assign rsp.valid     = valid_q;
	assign rsp.res_re    = re_q;
	assign rsp.res_im    = im_q;
	assign rsp.equal     = eq_q;
	assign rsp.div_zero  = dz_q;
	assign rsp.saturated = sat_q;

endmodule
`default_nettype wire
